// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Assertion that is also checked across reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== rtl/core/i2cts_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C target sequencer package
// Types, status codes and sizes shared by the sequencer modules.
// ---------------------------------------------------------------------------
package i2cts_pkg;

   localparam int DATA_DEPTH    = 64;
   localparam int COMMAND_DEPTH = 16;
   localparam int DATA_AW       = $clog2(DATA_DEPTH);
   localparam int POS_W         = 7;
   localparam int CLEN_W        = 5;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 7;

   localparam logic [POS_W-1:0]  DATA_DEPTH_P   = POS_W'(DATA_DEPTH);
   localparam logic [POS_W-1:0]  CMD_DEPTH_P    = POS_W'(COMMAND_DEPTH);
   localparam logic [CLEN_W-1:0] CMD_DEPTH_C    = CLEN_W'(COMMAND_DEPTH);
   localparam logic [POS_W-1:0]  DATA_CAP_RESET = POS_W'(DATA_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_CAPACITY  = 1'b1;

   // Serial interface status codes, target receiver and transmitter.
   localparam logic [7:0] ST_ADDR_W      = 8'h60;
   localparam logic [7:0] ST_ARB_ADDR_W  = 8'h68;
   localparam logic [7:0] ST_GCALL       = 8'h70;
   localparam logic [7:0] ST_ARB_GCALL   = 8'h78;
   localparam logic [7:0] ST_DATA_RX     = 8'h80;
   localparam logic [7:0] ST_GCALL_RX    = 8'h90;
   localparam logic [7:0] ST_STOP_RESTART = 8'hA0;
   localparam logic [7:0] ST_ARB_ADDR_R  = 8'hB0;
   localparam logic [7:0] ST_ADDR_R      = 8'hA8;
   localparam logic [7:0] ST_DATA_TX_ACK = 8'hB8;
   localparam logic [7:0] ST_DATA_TX_NAK = 8'hC0;
   localparam logic [7:0] TX_FILLER      = 8'h55;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_READY,
      PH_CMD,
      PH_RX,
      PH_TX
   } phase_type;

   typedef enum logic [1:0] {
      OP_EVENT,
      OP_BUF_WRITE,
      OP_RESTART,
      OP_STOP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [7:0]         bus_status;
      logic [7:0]         rx_byte;
      logic signed [7:0]  reply_length;
      logic [5:0]         buffer_index;
      logic [7:0]         buffer_byte;
   } req_type;

   typedef struct packed {
      logic               acknowledge;
      logic               tx_valid;
      logic [7:0]         tx_byte;
      logic               notify_valid;
      logic [4:0]         notify_command_length;
      logic [6:0]         notify_data_length;
      logic               general_call;
      logic               store_valid;
      logic               store_is_command;
      logic [5:0]         store_slot;
      logic [7:0]         store_value;
      logic               fault;
   } rsp_type;

   typedef struct packed {
      logic               en;
      logic [DATA_AW-1:0] addr;
      logic [7:0]         data;
   } buf_wr_type;

endpackage

// ===== rtl/core/i2cts_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C target sequencer channels
// Valid/ready interfaces for the request and response beats.
// ---------------------------------------------------------------------------
interface i2cts_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [7:0]        bus_status;
   logic [7:0]        rx_byte;
   logic signed [7:0] reply_length;
   logic [5:0]        buffer_index;
   logic [7:0]        buffer_byte;

   modport source (output valid, cmd, bus_status, rx_byte, reply_length, buffer_index,
                   buffer_byte, input ready);
   modport sink (input valid, cmd, bus_status, rx_byte, reply_length, buffer_index,
                 buffer_byte, output ready);
endinterface

interface i2cts_rsp_if;
   logic       valid;
   logic       ready;
   logic       acknowledge;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic       notify_valid;
   logic [4:0] notify_command_length;
   logic [6:0] notify_data_length;
   logic       general_call;
   logic       store_valid;
   logic       store_is_command;
   logic [5:0] store_slot;
   logic [7:0] store_value;
   logic       fault;

   modport source (output valid, acknowledge, tx_valid, tx_byte, notify_valid,
                   notify_command_length, notify_data_length, general_call, store_valid,
                   store_is_command, store_slot, store_value, fault, input ready);
   modport sink (input valid, acknowledge, tx_valid, tx_byte, notify_valid,
                 notify_command_length, notify_data_length, general_call, store_valid,
                 store_is_command, store_slot, store_value, fault, output ready);
endinterface

// ===== rtl/core/i2cts_buffer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C target data buffer
// Single-write memory with a registered, write-forwarding read port and a
// mirror of entry zero for transmits that restart at the first byte.
// ---------------------------------------------------------------------------
module i2cts_buffer import i2cts_pkg::*; (
   input  logic               clock,
   input  buf_wr_type         wr,
   input  logic [DATA_AW-1:0] rd_addr,
   output logic [7:0]         rd_data,
   output logic [7:0]         first_data
);

   logic [7:0] mem_ff [DATA_DEPTH];
   logic [7:0] rd_data_ff;
   logic [7:0] first_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      // A write to the entry being fetched must be seen by the next beat.
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr.en && (wr.addr == '0)) begin
         first_ff <= wr.data;
      end
   end

   assign rd_data    = rd_data_ff;
   assign first_data = first_ff;

endmodule

// ===== rtl/core/i2c_target_transaction_sequencer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C target transaction sequencer
// Steps a target-side I2C transaction on serial interface status codes.
// ---------------------------------------------------------------------------
// The req_bus channel carries one beat per bus event, buffer write, restart
// or stop; the rsp_bus channel returns exactly one beat for each of them, in
// order. The csr_ port writes the command length (index 0) and the data
// capacity (index 1); a capacity write also reloads the data limit. Write
// the registers only while no beat is in flight.
// A request beat is captured in an input register and evaluated there; when
// it fires, its response is captured in the response register and offered
// on rsp_bus. One beat is taken every cycle while the response side accepts.
// The data buffer is a memory with a registered read port; it is read ahead
// at the next byte position so transmits keep pace.
// Reset clears the phase to idle, acknowledge off, the byte position and
// general call flag to zero, the command length to zero and the data limit
// to the full buffer depth. Buffer contents are undefined until written.
// When the response side stalls, the finished beat is held and one more
// request is taken into the input register before req ready drops.
// ---------------------------------------------------------------------------
module i2c_target_transaction_sequencer import i2cts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   i2cts_req_if.sink             req_bus,
   i2cts_rsp_if.source           rsp_bus,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   // Input stage and response register.
   logic       s1_valid_ff;
   req_type    s1_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       fire;

   // Sequencer state.
   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               gcall_ff, gcall_in;
   logic [POS_W-1:0]   limit_ff, limit_in;
   logic               ack_ff, ack_in;
   logic [CLEN_W-1:0]  cmd_len_ff;

   logic [CLEN_W-1:0]  clen;
   logic               is_addr, is_rx, is_end, is_tx_start, is_tx_next, is_release;
   logic               err;
   phase_type          rx_phase;
   logic [POS_W-1:0]   rx_pos, rx_pos_next, tx_pos;
   logic               rx_room, tx_room;
   logic [POS_W-1:0]   reply_limit;

   buf_wr_type         buf_wr;
   logic [7:0]         buf_rd_data;
   logic [7:0]         buf_first_data;

   assign fire        = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.valid && req_bus.ready) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_ff.op           <= op_type'(req_bus.cmd);
         s1_ff.bus_status   <= req_bus.bus_status;
         s1_ff.rx_byte      <= req_bus.rx_byte;
         s1_ff.reply_length <= req_bus.reply_length;
         s1_ff.buffer_index <= req_bus.buffer_index;
         s1_ff.buffer_byte  <= req_bus.buffer_byte;
      end
   end

   assign clen = (cmd_len_ff > CMD_DEPTH_C) ? CMD_DEPTH_C : cmd_len_ff;

   // A data byte while ready opens the command part at position zero.
   assign rx_phase    = (phase_ff == PH_READY) ? PH_CMD : phase_ff;
   assign rx_pos      = (phase_ff == PH_READY) ? '0 : pos_ff;
   assign rx_pos_next = rx_pos + POS_W'(1);
   assign rx_room     = (rx_pos < limit_ff) && (rx_pos < DATA_DEPTH_P);
   assign tx_pos      = is_tx_start ? '0 : pos_ff;
   assign tx_room     = (tx_pos < limit_ff) && (tx_pos < DATA_DEPTH_P);
   assign reply_limit = (s1_ff.reply_length > 8'sd64) ? DATA_DEPTH_P
                                                      : s1_ff.reply_length[POS_W-1:0];

   // Status code decode and protocol error check.
   always_comb begin
      is_addr     = 1'b0;
      is_rx       = 1'b0;
      is_end      = 1'b0;
      is_tx_start = 1'b0;
      is_tx_next  = 1'b0;
      is_release  = 1'b0;
      err         = 1'b0;
      case (s1_ff.bus_status)
         ST_ADDR_W, ST_ARB_ADDR_W, ST_GCALL, ST_ARB_GCALL: begin
            is_addr = 1'b1;
            err     = (phase_ff != PH_READY);
         end
         ST_DATA_RX, ST_GCALL_RX: begin
            is_rx = 1'b1;
            err   = (rx_phase != PH_CMD) && (rx_phase != PH_RX);
         end
         ST_STOP_RESTART: begin
            is_end = 1'b1;
         end
         ST_ARB_ADDR_R, ST_ADDR_R: begin
            is_tx_start = 1'b1;
            err         = (clen != '0) && (phase_ff != PH_TX);
         end
         ST_DATA_TX_ACK: begin
            is_tx_next = 1'b1;
            err        = (phase_ff != PH_TX);
         end
         ST_DATA_TX_NAK: begin
            is_release = 1'b1;
         end
         default: begin
            err = 1'b1;
         end
      endcase
   end

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      gcall_in = gcall_ff;
      limit_in = limit_ff;
      ack_in   = ack_ff;
      if (fire) begin
         case (s1_ff.op)
            OP_RESTART: begin
               if (phase_ff == PH_IDLE) begin
                  phase_in = PH_READY;
                  ack_in   = 1'b1;
               end
            end
            OP_STOP: begin
               phase_in = PH_IDLE;
               ack_in   = 1'b0;
            end
            OP_EVENT: begin
               if (err) begin
                  phase_in = PH_READY;
                  ack_in   = 1'b1;
               end else if (is_addr) begin
                  pos_in   = '0;
                  gcall_in = (s1_ff.bus_status == ST_GCALL) ||
                             (s1_ff.bus_status == ST_ARB_GCALL);
                  phase_in = (clen != '0) ? PH_CMD : PH_RX;
                  ack_in   = 1'b1;
               end else if (is_rx) begin
                  if (rx_phase == PH_CMD) begin
                     ack_in = 1'b1;
                     if (rx_pos_next >= POS_W'(clen)) begin
                        pos_in   = '0;
                        phase_in = PH_RX;
                     end else begin
                        pos_in   = rx_pos_next;
                        phase_in = PH_CMD;
                     end
                  end else begin
                     phase_in = PH_RX;
                     pos_in   = rx_room ? rx_pos_next : rx_pos;
                     ack_in   = rx_room;
                  end
               end else if (is_end) begin
                  ack_in = 1'b1;
                  if (s1_ff.reply_length <= 8'sd0) begin
                     phase_in = PH_READY;
                  end else begin
                     limit_in = reply_limit;
                     pos_in   = '0;
                     phase_in = PH_TX;
                  end
               end else if (is_tx_start || is_tx_next) begin
                  phase_in = PH_TX;
                  pos_in   = tx_room ? (tx_pos + POS_W'(1)) : tx_pos;
               end else if (is_release) begin
                  phase_in = PH_READY;
                  ack_in   = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      // A capacity write reloads the data limit at once.
      if (csr_write_en && (csr_index == CSR_DATA_CAPACITY)) begin
         limit_in = (csr_write_data > DATA_DEPTH_P) ? DATA_DEPTH_P : csr_write_data;
      end
   end

   // Response fields.
   always_comb begin
      rsp_in              = '0;
      rsp_in.acknowledge  = ack_in;
      rsp_in.general_call = gcall_in;
      case (s1_ff.op)
         OP_RESTART: begin
            rsp_in.fault = (phase_ff != PH_IDLE);
         end
         OP_EVENT: begin
            rsp_in.fault = err;
            if (!err && is_rx && ((rx_phase == PH_CMD) || rx_room)) begin
               rsp_in.store_valid      = 1'b1;
               rsp_in.store_is_command = (rx_phase == PH_CMD);
               rsp_in.store_slot       = rx_pos[DATA_AW-1:0];
               rsp_in.store_value      = s1_ff.rx_byte;
            end
            if (is_end) begin
               rsp_in.notify_valid = 1'b1;
               if (phase_ff == PH_RX) begin
                  rsp_in.notify_command_length = clen;
                  rsp_in.notify_data_length    = pos_ff;
               end else begin
                  rsp_in.notify_command_length = (pos_ff > CMD_DEPTH_P) ? CMD_DEPTH_C
                                                                       : pos_ff[CLEN_W-1:0];
               end
            end
            if (!err && (is_tx_start || is_tx_next)) begin
               rsp_in.tx_valid = 1'b1;
               if (!tx_room) begin
                  rsp_in.tx_byte = TX_FILLER;
               end else if (is_tx_start) begin
                  rsp_in.tx_byte = buf_first_data;
               end else begin
                  rsp_in.tx_byte = buf_rd_data;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Buffer writes come from the host or from received data bytes.
   always_comb begin
      buf_wr      = '0;
      buf_wr.en   = 1'b0;
      buf_wr.addr = s1_ff.buffer_index;
      buf_wr.data = s1_ff.buffer_byte;
      if (fire) begin
         if (s1_ff.op == OP_BUF_WRITE) begin
            buf_wr.en = ({1'b0, s1_ff.buffer_index} < DATA_DEPTH_P);
         end else if ((s1_ff.op == OP_EVENT) && !err && is_rx &&
                      (rx_phase == PH_RX) && rx_room) begin
            buf_wr.en   = 1'b1;
            buf_wr.addr = rx_pos[DATA_AW-1:0];
            buf_wr.data = s1_ff.rx_byte;
         end
      end
   end

   i2cts_buffer u_buffer (
      .clock      (clock),
      .wr         (buf_wr),
      .rd_addr    (pos_in[DATA_AW-1:0]),
      .rd_data    (buf_rd_data),
      .first_data (buf_first_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pos_ff     <= '0;
         gcall_ff   <= 1'b0;
         limit_ff   <= DATA_CAP_RESET;
         ack_ff     <= 1'b0;
         cmd_len_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         gcall_ff <= gcall_in;
         limit_ff <= limit_in;
         ack_ff   <= ack_in;
         if (csr_write_en && (csr_index == CSR_COMMAND_LENGTH)) begin
            cmd_len_ff <= csr_write_data[CLEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid                 = rsp_valid_ff;
   assign rsp_bus.acknowledge           = rsp_ff.acknowledge;
   assign rsp_bus.tx_valid              = rsp_ff.tx_valid;
   assign rsp_bus.tx_byte               = rsp_ff.tx_byte;
   assign rsp_bus.notify_valid          = rsp_ff.notify_valid;
   assign rsp_bus.notify_command_length = rsp_ff.notify_command_length;
   assign rsp_bus.notify_data_length    = rsp_ff.notify_data_length;
   assign rsp_bus.general_call          = rsp_ff.general_call;
   assign rsp_bus.store_valid           = rsp_ff.store_valid;
   assign rsp_bus.store_is_command      = rsp_ff.store_is_command;
   assign rsp_bus.store_slot            = rsp_ff.store_slot;
   assign rsp_bus.store_value           = rsp_ff.store_value;
   assign rsp_bus.fault                 = rsp_ff.fault;

endmodule

// ===== rtl/core/i2cts_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C target sequencer checker
// Port-level checks on the response channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cts_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic acknowledge,
   input logic tx_valid,
   input logic notify_valid,
   input logic store_valid
);

   // A held response beat must not be dropped.
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped while stalled")

   `CHK_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "rsp valid right after reset")

   // A beat reports at most one of transmit, store and end of transaction.
   `CHK_ASSERT(a_one_kind, clock, reset, rsp_valid |-> $countones({tx_valid, notify_valid, store_valid}) <= 1, "rsp beat mixes transmit, store and notify")

   // Storing a byte or ending a transaction always leaves acknowledge on.
   `CHK_ASSERT(a_ack_on, clock, reset, rsp_valid && (notify_valid || store_valid) |-> acknowledge, "acknowledge off after store or notify")

endmodule

bind i2c_target_transaction_sequencer i2cts_checker u_i2cts_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .acknowledge  (rsp_bus.acknowledge),
   .tx_valid     (rsp_bus.tx_valid),
   .notify_valid (rsp_bus.notify_valid),
   .store_valid  (rsp_bus.store_valid)
);
